// File: design/skcm_pkg.sv
// Shared constants and types for the stochastic %K crossover marker.
// No dependencies; imported by the top level.
package skcm_pkg;

  // %K value, 1/256 percent units
  localparam int K_W = 15;
  typedef logic [K_W-1:0] kval_t;

  localparam kval_t K_FULL = 15'd25600;
  localparam kval_t K_HALF = 15'd12800;

  // configuration register widths
  localparam int WL_W  = 7;
  localparam int LVL_W = 15;
  localparam int OFF_W = 16;

  // APB port geometry
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // register indexes (paddr[3:2])
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_WINDOW = 2'd0;
  localparam reg_idx_t REG_LEVEL  = 2'd1;
  localparam reg_idx_t REG_OFFSET = 2'd2;

  // reset values of the registers
  localparam logic [WL_W-1:0]  WINDOW_RST = 7'd10;
  localparam logic [LVL_W-1:0] LEVEL_RST  = 15'd5120;
  localparam logic [OFF_W-1:0] OFFSET_RST = 16'd3;

endpackage

// File: design/skcm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module skcm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/stochastic_k_crossover_marker.sv
// Fast stochastic %K crossover marker, top level.
// Depends on skcm_pkg and skcm_ram.
//
// Usage
//   s_* channel takes one price bar per item (high, low, close). m_* channel
//   returns one result per bar: fast %K, a marker flag in tuser and the
//   marker price. Registers sit behind the APB port: window length at 0x0,
//   crossover level at 0x4, marker offset at 0x8; write them only while idle.
//   Each bar is written into a ring memory of {high, low} pairs; the window is
//   then read back one entry per cycle through the RAM's single read port to
//   find the highest high and lowest low, then %K is formed by a 15x price
//   multiply and a 15-step restoring divider (one quotient bit per cycle).
//   A warm-up bar skips the scan and the divider; a flat window or a close
//   outside it skips only the divider; the general case runs both, the scan
//   covering the clamped window length.
//   m_tvalid rises at the edge that returns the block to idle.
//   The result lands in an output register, so the next bar is accepted while
//   a finished result waits; a stalled receiver holds the block only when a
//   second result is ready before the first has been taken.
//   Reset (rst, synchronous) restores the register defaults, empties the
//   bar count, sets the previous %K to fifty percent and drops m_tvalid. The
//   ring needs no clearing: only entries written since reset are read.
module stochastic_k_crossover_marker
  import skcm_pkg::*;
#(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // bar items
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // {close_price, low_price, high_price}, high_price in the lowest bits
  input  logic [((3*PRICE_BITS+7)/8)*8-1:0]         s_tdata,
  // result items
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // {pad, dot_price, fast_k}, fast_k in the lowest bits
  output logic [((K_W+PRICE_BITS+7)/8)*8-1:0]       m_tdata,
  // dot_valid
  output logic                                      m_tuser,
  // configuration
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [PADDR_W-1:0]                        paddr,
  input  logic [PDATA_W-1:0]                        pwdata,
  output logic [PDATA_W-1:0]                        prdata,
  output logic                                      pready
);

  localparam int P       = PRICE_BITS;
  localparam int OUT_W   = ((K_W+P+7)/8)*8;
  localparam int AW      = $clog2(MAX_WINDOW);
  localparam int PER_W   = $clog2(MAX_WINDOW+1);
  localparam int CMP_W   = (PER_W > WL_W) ? PER_W : WL_W;
  localparam int PROD_W  = P + K_W;
  localparam int DCNT_W  = $clog2(K_W);
  localparam int DIFF_W  = (P > OFF_W) ? P : OFF_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // configuration registers
  logic [WL_W-1:0]  window_length;
  logic [LVL_W-1:0] cross_level;
  logic [OFF_W-1:0] dot_offset_ticks;

  // control state
  logic [2:0]       state;
  logic [AW-1:0]    ring_ptr;
  logic [PER_W-1:0] bars_seen;
  kval_t            prev_k;
  logic             warm;
  logic [PER_W-1:0] period_q;
  logic [PER_W-1:0] scan_cnt;
  logic [AW-1:0]    rd_ptr;
  logic             rd_pend;
  logic [DCNT_W-1:0] div_cnt;

  // item payload and working values
  logic [P-1:0]      low_q;
  logic [P-1:0]      close_q;
  logic [P-1:0]      hh;
  logic [P-1:0]      ll;
  logic [P-1:0]      num;
  logic [P-1:0]      den;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] dvs;
  kval_t             k_res;

  // output register
  kval_t        out_k;
  logic         out_dot_valid;
  logic [P-1:0] out_dot_price;

  // ring memory
  logic [2*P-1:0] ram_rdata;
  logic           in_accept;

  logic [P-1:0] in_high;
  logic [P-1:0] in_low;
  logic [P-1:0] in_close;

  logic [P-1:0]      rd_high;
  logic [P-1:0]      rd_low;
  logic [PER_W-1:0]  period_c;
  logic [CMP_W-1:0]  wl_ext;
  logic              out_free;
  logic              div_ge;
  logic              marker;
  logic [DIFF_W-1:0] low_ext;
  logic [DIFF_W-1:0] off_ext;
  logic [P-1:0]      dot_calc;

  assign in_high  = s_tdata[P-1:0];
  assign in_low   = s_tdata[2*P-1:P];
  assign in_close = s_tdata[3*P-1:2*P];

  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign rd_high = ram_rdata[2*P-1:P];
  assign rd_low  = ram_rdata[P-1:0];

  // window length clamped to 1..MAX_WINDOW
  always_comb begin
    wl_ext = CMP_W'(window_length);
    if (window_length == '0) begin
      period_c = PER_W'(1);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      period_c = PER_W'(MAX_WINDOW);
    end else begin
      period_c = PER_W'(window_length);
    end
  end

  // one restoring division step
  assign div_ge = (rem >= dvs);

  // crossover test and marker price
  assign marker  = !warm && (LVL_W'(prev_k) <= cross_level) && (LVL_W'(k_res) > cross_level);
  assign low_ext = DIFF_W'(low_q);
  assign off_ext = DIFF_W'(dot_offset_ticks);
  assign dot_calc = (low_ext > off_ext) ? P'(low_ext - off_ext) : '0;

  skcm_ram #(
    .WIDTH (2*P),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (in_accept),
    .waddr (ring_ptr),
    .wdata ({in_high, in_low}),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length    <= WINDOW_RST;
      cross_level      <= LEVEL_RST;
      dot_offset_ticks <= OFFSET_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_WINDOW: window_length    <= pwdata[WL_W-1:0];
        REG_LEVEL:  cross_level      <= pwdata[LVL_W-1:0];
        REG_OFFSET: dot_offset_ticks <= pwdata[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // configuration reads
  always_comb begin
    case (paddr[3:2])
      REG_WINDOW: prdata = PDATA_W'(window_length);
      REG_LEVEL:  prdata = PDATA_W'(cross_level);
      REG_OFFSET: prdata = PDATA_W'(dot_offset_ticks);
      default:    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // sequencer: control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ring_ptr  <= '0;
      bars_seen <= '0;
      prev_k    <= K_HALF;
      rd_pend   <= 1'b0;
      scan_cnt  <= '0;
      div_cnt   <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      // result handshake
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            ring_ptr <= (ring_ptr == AW'(MAX_WINDOW-1)) ? '0 : ring_ptr + 1'b1;
            if (bars_seen != PER_W'(MAX_WINDOW)) begin
              bars_seen <= bars_seen + 1'b1;
            end
            scan_cnt <= '0;
            rd_pend  <= 1'b0;
            state    <= (bars_seen < period_c) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_cnt != period_q) begin
            scan_cnt <= scan_cnt + 1'b1;
          end
          rd_pend <= (scan_cnt != period_q);
          if (rd_pend && scan_cnt == period_q) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (hh <= ll || close_q <= ll || (close_q - ll) >= (hh - ll)) begin
            state <= S_DONE;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DCNT_W'(K_W-1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            prev_k   <= k_res;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // sequencer: datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        low_q    <= in_low;
        close_q  <= in_close;
        warm     <= (bars_seen < period_c);
        period_q <= period_c;
        rd_ptr   <= ring_ptr;
        hh       <= '0;
        ll       <= '1;
        k_res    <= K_HALF;
      end
      S_SCAN: begin
        // walk back from the newest bar, one entry per cycle
        if (scan_cnt != period_q) begin
          rd_ptr <= (rd_ptr == '0) ? AW'(MAX_WINDOW-1) : rd_ptr - 1'b1;
        end
        if (rd_pend) begin
          if (rd_high > hh) begin
            hh <= rd_high;
          end
          if (rd_low < ll) begin
            ll <= rd_low;
          end
        end
      end
      S_EVAL: begin
        num <= close_q - ll;
        den <= hh - ll;
        if (hh <= ll) begin
          k_res <= prev_k;
        end else if (close_q <= ll) begin
          k_res <= '0;
        end else if ((close_q - ll) >= (hh - ll)) begin
          k_res <= K_FULL;
        end
      end
      S_MUL: begin
        rem   <= PROD_W'(num) * PROD_W'(K_FULL);
        dvs   <= PROD_W'(den) << (K_W-1);
        k_res <= '0;
      end
      S_DIV: begin
        if (div_ge) begin
          rem <= rem - dvs;
        end
        dvs   <= dvs >> 1;
        k_res <= {k_res[K_W-2:0], div_ge};
      end
      S_DONE: begin
        if (out_free) begin
          out_k         <= k_res;
          out_dot_valid <= marker;
          out_dot_price <= marker ? dot_calc : '0;
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = OUT_W'({out_dot_price, out_k});
  assign m_tuser = out_dot_valid;

  // checks
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_k <= K_FULL))
    else $error("fast_k above full scale");

  a_marker_above_level: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_dot_valid) |-> (LVL_W'(out_k) > cross_level))
    else $error("marker raised with K not above level");

  a_no_dot_price: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_dot_valid) |-> (out_dot_price == '0))
    else $error("marker price set without marker");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_cnt <= period_q))
    else $error("window scan overran the period");

endmodule

// File: tb/testbench.sv
// Self-checking bench for stochastic_k_crossover_marker: bars in, %K and crossover markers out.
// Depends on skcm_pkg and the design sources; it carries its own %K predictor and a
// result queue, and uses APB writes and read-backs for the registers.
module testbench;
  import skcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_DEPTH      = 64;
  localparam int PRICE_W        = 32;
  localparam int BAR_W          = ((3*PRICE_W+7)/8)*8;
  localparam int RES_W          = ((K_W+PRICE_W+7)/8)*8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 800;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_CYCLES     = 100;
  localparam int CHUNK_BARS     = 35;
  localparam int MAX_REPORTS    = 60;

  // index that is not in the register map
  localparam reg_idx_t REG_UNUSED = 2'd3;

  typedef logic [PRICE_W-1:0] price_t;

  typedef struct packed {
    kval_t  fast_k;
    logic   dot_valid;
    price_t dot_price;
  } k_marker_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             s_tvalid = 1'b0;
  logic             s_tready;
  // {close_price, low_price, high_price}, high_price lowest
  logic [BAR_W-1:0] s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  // {pad, dot_price, fast_k}, fast_k lowest
  logic [RES_W-1:0] m_tdata;
  // dot_valid
  logic             m_tuser;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  stochastic_k_crossover_marker u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: register copies, bar history, previous %K
  logic [WL_W-1:0]  win_cfg = WINDOW_RST;
  logic [LVL_W-1:0] lvl_cfg = LEVEL_RST;
  logic [OFF_W-1:0] off_cfg = OFFSET_RST;
  price_t           high_hist [WIN_DEPTH];
  price_t           low_hist  [WIN_DEPTH];
  logic [5:0]       hist_wr   = '0;
  logic [6:0]       bars_held = '0;
  kval_t            last_k    = K_HALF;

  k_marker_t k_marker_q[$];

  int mismatches    = 0;
  int bars_sent     = 0;
  int results_seen  = 0;
  int markers_seen  = 0;
  int settings_used = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // receiver hold-off request, toggled by the stimulus
  logic hold_go   = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  // random walk state for bar prices
  longint      walk_mid    = 64'd100000;
  int unsigned walk_spread = 100;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("ERROR %s: got 0x%0h, expected 0x%0h (after %0d results)",
               what, got, want, results_seen);
  endtask

  // %K and marker for one accepted bar; updates the history as the block does
  function automatic k_marker_t compute_k_marker(price_t hi, price_t lo, price_t cl);
    k_marker_t       r;
    int unsigned     span;
    logic [5:0]      idx;
    price_t          top;
    price_t          bottom;
    longint unsigned num;
    longint unsigned den;
    span = (win_cfg == 0) ? 1 : ((win_cfg > WIN_DEPTH) ? WIN_DEPTH : win_cfg);
    high_hist[hist_wr] = hi;
    low_hist[hist_wr]  = lo;
    hist_wr = hist_wr + 6'd1;
    r = '0;
    if (bars_held < span) begin
      r.fast_k = K_HALF;
    end else begin
      top    = '0;
      bottom = '1;
      for (int i = 0; i < span; i++) begin
        idx = hist_wr - 6'd1 - 6'(i);
        if (high_hist[idx] > top) top = high_hist[idx];
        if (low_hist[idx] < bottom) bottom = low_hist[idx];
      end
      if (top <= bottom) begin
        r.fast_k = last_k;
      end else if (cl <= bottom) begin
        r.fast_k = '0;
      end else if (cl - bottom >= top - bottom) begin
        r.fast_k = K_FULL;
      end else begin
        num = longint'(cl - bottom);
        den = longint'(top - bottom);
        r.fast_k = kval_t'((num * longint'(K_FULL)) / den);
      end
      // crossing from at-or-below the level to above it
      if (last_k <= lvl_cfg && r.fast_k > lvl_cfg) begin
        r.dot_valid = 1'b1;
        r.dot_price = (lo > price_t'(off_cfg)) ? lo - price_t'(off_cfg) : '0;
      end
    end
    if (bars_held < WIN_DEPTH) bars_held = bars_held + 7'd1;
    last_k = r.fast_k;
    return r;
  endfunction

  // one bar item; optional idle cycles before it
  task automatic send_bar(input price_t hi, input price_t lo, input price_t cl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {cl, lo, hi};
    do @(posedge clk); while (!s_tready);
    k_marker_q.push_back(compute_k_marker(hi, lo, cl));
    bars_sent++;
  endtask

  // wait for every expected result, then a short settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (k_marker_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_cycle(input logic wr, input reg_idx_t idx, input logic [PDATA_W-1:0] wdata,
                           output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // read all three registers back against the predictor's copies
  task automatic check_registers();
    logic [PDATA_W-1:0] rd;
    apb_cycle(1'b0, REG_WINDOW, '0, rd);
    if (rd !== PDATA_W'(win_cfg)) report_mismatch("window_length read", rd, win_cfg);
    apb_cycle(1'b0, REG_LEVEL, '0, rd);
    if (rd !== PDATA_W'(lvl_cfg)) report_mismatch("cross_level read", rd, lvl_cfg);
    apb_cycle(1'b0, REG_OFFSET, '0, rd);
    if (rd !== PDATA_W'(off_cfg)) report_mismatch("dot_offset_ticks read", rd, off_cfg);
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    apb_cycle(1'b1, idx, value, rd);
    case (idx)
      REG_WINDOW: win_cfg = value[WL_W-1:0];
      REG_LEVEL:  lvl_cfg = value[LVL_W-1:0];
      REG_OFFSET: off_cfg = value[OFF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [PDATA_W-1:0] win, input logic [PDATA_W-1:0] lvl,
                         input logic [PDATA_W-1:0] off);
    set_reg(REG_WINDOW, win);
    set_reg(REG_LEVEL, lvl);
    set_reg(REG_OFFSET, off);
    check_registers();
    settings_used++;
  endtask

  function automatic price_t clamp_price(longint v);
    if (v < 0) return '0;
    if (v > longint'(32'hFFFF_FFFF)) return '1;
    return price_t'(v);
  endfunction

  function automatic price_t pick_extreme(longint mid);
    case ($urandom_range(0, 2))
      0: return '0;
      1: return '1;
      default: return clamp_price(mid);
    endcase
  endfunction

  // mostly well-formed bars around a random walk, some flat, some noise
  task automatic random_bar();
    int unsigned pick;
    longint      h;
    longint      l;
    longint      c;
    longint      sp;
    pick = $urandom_range(0, 99);
    sp   = walk_spread;
    if (pick < 3) walk_mid = $urandom_range(0, 200);
    else if (pick < 5) walk_mid = 64'hFFFF_FF00 + $urandom_range(0, 255);
    walk_mid = walk_mid + longint'($urandom_range(0, 2*walk_spread)) - sp;
    walk_mid = longint'(clamp_price(walk_mid));
    if (pick < 70) begin
      h = walk_mid + $urandom_range(0, walk_spread);
      l = walk_mid - $urandom_range(0, walk_spread);
      c = walk_mid + longint'($urandom_range(0, 2*walk_spread)) - sp;
      send_bar(clamp_price(h), clamp_price(l), clamp_price(c));
    end else if (pick < 78) begin
      send_bar(clamp_price(walk_mid), clamp_price(walk_mid), clamp_price(walk_mid));
    end else if (pick < 90) begin
      send_bar($urandom, $urandom, $urandom);
    end else begin
      send_bar(pick_extreme(walk_mid), pick_extreme(walk_mid), pick_extreme(walk_mid));
    end
  endtask

  // register settings per chunk, extremes visited in rotation
  task automatic random_settings(input int n);
    logic [PDATA_W-1:0] win;
    logic [PDATA_W-1:0] lvl;
    logic [PDATA_W-1:0] off;
    case (n % 9)
      2: win = 0;
      4: win = 127;
      7: win = WIN_DEPTH;
      default: win = ($urandom_range(0, 99) < 20) ? $urandom_range(17, 63) : $urandom_range(1, 16);
    endcase
    case (n % 5)
      0: lvl = 0;
      1: lvl = K_FULL;
      2: lvl = 32767;
      default: lvl = $urandom_range(0, K_FULL);
    endcase
    case (n % 4)
      0: off = 0;
      1: off = 65535;
      default: off = $urandom_range(0, 65535);
    endcase
    walk_spread = $urandom_range(1, 1 << $urandom_range(1, 20));
    set_all(win, lvl, off);
  endtask

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin : result_check
    k_marker_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (k_marker_q.size() == 0) begin
        report_mismatch("result with nothing expected", m_tdata, 0);
      end else begin
        want = k_marker_q.pop_front();
        if (m_tdata[K_W-1:0] !== want.fast_k)
          report_mismatch("fast_k", m_tdata[K_W-1:0], want.fast_k);
        if (m_tuser !== want.dot_valid)
          report_mismatch("dot_valid", m_tuser, want.dot_valid);
        if (m_tdata[K_W +: PRICE_W] !== want.dot_price)
          report_mismatch("dot_price", m_tdata[K_W +: PRICE_W], want.dot_price);
      end
      results_seen++;
      if (m_tuser === 1'b1) markers_seen++;
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("stochastic_k_crossover_marker: mismatch");
      $finish;
    end
  end

  task automatic test_register_defaults();
    check_registers();
  endtask

  // warm-up, flat bar, close outside the range, marker saturation, price extremes
  task automatic test_directed_bars();
    set_all(0, LEVEL_RST, OFFSET_RST);   // zero window acts as one bar
    send_bar(500, 400, 450);
    send_bar(100, 100, 100);
    send_bar(200, 100, 50);
    send_bar(200, 2, 300);
    send_bar(200, 100, 100);
    send_bar(32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
    send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_bar(32'hFFFF_FFFF, 32'h0, 32'h1);
    send_bar(1000, 10, 500);
    wait_drained();
    set_all(1, 0, 65535);
    send_bar(80000, 70000, 60000);
    send_bar(80000, 70000, 75000);
    send_bar(32'h0, 32'hFFFF_FFFF, 5);
    wait_drained();
  endtask

  // oversize window clamps, then a shrink keeps the warm-up count
  task automatic test_window_limits();
    set_all(127, 32767, 65535);
    send_bar(900, 100, 500);
    send_bar(950, 50, 900);
    send_bar(700, 300, 200);
    wait_drained();
    set_all(3, 12000, 40);
    send_bar(500, 400, 450);
    send_bar(600, 350, 590);
    send_bar(620, 300, 310);
    send_bar(620, 300, 620);
    wait_drained();
  endtask

  task automatic test_ignored_register();
    logic [PDATA_W-1:0] rd;
    apb_cycle(1'b1, REG_UNUSED, 32'hFFFF_FFFF, rd);
    check_registers();
    send_bar(700, 100, 650);
    send_bar(700, 100, 150);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int sidle, input int ridle, input int chunks);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int n = 0; n < chunks; n++) begin
      wait_drained();
      random_settings(settings_used);
      repeat (CHUNK_BARS) random_bar();
    end
    wait_drained();
  endtask

  // receiver holds off while bars keep coming, so the input side backs up
  task automatic test_receiver_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_all(5, 6400, 100);
    hold_go <= ~hold_go;
    repeat (30) random_bar();
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_defaults();
    test_directed_bars();
    test_window_limits();
    test_ignored_register();
    test_random_traffic(13, 49, 10);
    test_random_traffic(49, 13, 10);
    test_random_traffic(0, 0, 9);
    test_receiver_hold();

    // tail: let any stray result show up
    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (k_marker_q.size() != 0)
      report_mismatch("results never delivered", 0, k_marker_q.size());
    $display("run covered %0d bars, %0d results, %0d crossover markers", bars_sent,
             results_seen, markers_seen);
    $display("%0d register settings incl. zero/oversize windows and level/offset extremes",
             settings_used);
    if (mismatches == 0) begin
      $display("stochastic_k_crossover_marker: match");
    end else begin
      $display("stochastic_k_crossover_marker: mismatch");
    end
    $finish;
  end

endmodule

// File: stochastic_k_crossover_marker.f
design/skcm_pkg.sv
design/skcm_ram.sv
design/stochastic_k_crossover_marker.sv
tb/testbench.sv
